// ===== src/ntcl_pkg.sv =====
`default_nettype none

package ntcl_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = IDX_W + 1;
  localparam int TIME_W      = 63;
  localparam int PAY_W       = 32;

  localparam logic [CNT_W-1:0] COUNT_FULL = CNT_W'(TABLE_DEPTH);
  localparam logic [CNT_W-1:0] COUNT_ONE  = CNT_W'(1);
  localparam logic [IDX_W-1:0] IDX_ONE    = IDX_W'(1);

  typedef enum logic {
    OP_APPEND = 1'b0,
    OP_QUERY  = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_BELOW = 3'd1,
    ST_ABOVE = 3'd2,
    ST_EMPTY = 3'd3,
    ST_FULL  = 3'd4
  } status_t;

endpackage

`default_nettype wire

// ===== src/ntcl_ram.sv =====
`default_nettype none

module ntcl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// ===== src/nearest_timestamp_cursor_lookup_unit.sv =====
// Append, table-full and table-empty results are registered in the cycle after the beat.
// Query: below-minimum is decided on entry zero, above-maximum on the last entry; an exact
// last-time hit reads the payload; others scan k entries and may compare the earlier neighbor.
// Throughput: one item at a time; the scan reads the time memory once per cycle.
// Reset (rst_n low, synchronous) clears the sequencer, entry count, cursor and output valid;
// the time and payload memories keep their contents and get no clearing pass.
`default_nettype none

module nearest_timestamp_cursor_lookup_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [95:0] in_tdata,   // query_time[62:0], entry_payload[94:63], zero pad
  input  wire logic        in_tuser,   // operation
  // result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [47:0] out_tdata   // status[2:0], found_index[12:3],
                                       // found_payload[44:13], zero pad
);

  localparam int IDX_W  = ntcl_pkg::IDX_W;
  localparam int CNT_W  = ntcl_pkg::CNT_W;
  localparam int TIME_W = ntcl_pkg::TIME_W;
  localparam int PAY_W  = ntcl_pkg::PAY_W;

  typedef enum logic [2:0] {
    S_IDLE,   // wait for a beat
    S_CHK0,   // time of entry zero on the read port
    S_CHKL,   // time of the last entry on the read port
    S_SCAN,   // walk forward from the cursor, one entry per cycle
    S_PREV,   // time of the entry before the later one on the read port
    S_CMP,    // compare the two distances
    S_PAYW,   // payload read issued
    S_PAY     // payload on the read port, emit the result
  } state_t;

  state_t                   state_r,  state_nxt;
  logic [CNT_W-1:0]         count_r,  count_nxt;
  logic [IDX_W-1:0]         cursor_r, cursor_nxt;
  logic [IDX_W-1:0]         idx_r,    idx_nxt;
  logic [IDX_W-1:0]         pick_r,   pick_nxt;
  logic [TIME_W-1:0]        qtime_r,  qtime_nxt;
  logic [TIME_W-1:0]        dhi_r,    dhi_nxt;
  logic [TIME_W-1:0]        dlo_r,    dlo_nxt;
  logic                     out_valid_r,   out_valid_nxt;
  ntcl_pkg::status_t        out_status_r,  out_status_nxt;
  logic [IDX_W-1:0]         out_index_r,   out_index_nxt;
  logic [PAY_W-1:0]         out_payload_r, out_payload_nxt;

  logic                     out_free;
  logic                     in_acc;
  logic                     is_append;
  logic                     full;
  logic [CNT_W-1:0]         last_cnt;
  logic [IDX_W-1:0]         last_idx;
  logic [IDX_W-1:0]         cursor_fix;
  logic                     wr_en;
  logic [IDX_W-1:0]         t_raddr;
  logic [TIME_W-1:0]        t_rdata;
  logic [PAY_W-1:0]         p_rdata;
  logic [TIME_W-1:0]        in_time;
  logic [PAY_W-1:0]         in_payload;

  assign in_time    = in_tdata[TIME_W-1:0];
  assign in_payload = in_tdata[TIME_W+PAY_W-1:TIME_W];

  assign out_free   = !out_valid_r || out_tready;
  assign in_tready  = (state_r == S_IDLE) && out_free;
  assign in_acc     = in_tvalid && in_tready;
  assign is_append  = (in_tuser == ntcl_pkg::OP_APPEND);
  assign full       = (count_r >= ntcl_pkg::COUNT_FULL);
  assign last_cnt   = count_r - ntcl_pkg::COUNT_ONE;
  assign last_idx   = last_cnt[IDX_W-1:0];
  // a cursor past the end restarts the scan at entry zero
  assign cursor_fix = ({1'b0, cursor_r} >= count_r) ? '0 : cursor_r;
  assign wr_en      = in_acc && is_append && !full;

  ntcl_ram #(
    .WIDTH (TIME_W),
    .DEPTH (ntcl_pkg::TABLE_DEPTH)
  ) u_time_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count_r[IDX_W-1:0]),
    .wr_data (in_time),
    .rd_addr (t_raddr),
    .rd_data (t_rdata)
  );

  ntcl_ram #(
    .WIDTH (PAY_W),
    .DEPTH (ntcl_pkg::TABLE_DEPTH)
  ) u_pay_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count_r[IDX_W-1:0]),
    .wr_data (in_payload),
    .rd_addr (pick_r),
    .rd_data (p_rdata)
  );

  always_comb begin
    state_nxt       = state_r;
    count_nxt       = count_r;
    cursor_nxt      = cursor_r;
    idx_nxt         = idx_r;
    pick_nxt        = pick_r;
    qtime_nxt       = qtime_r;
    dhi_nxt         = dhi_r;
    dlo_nxt         = dlo_r;
    out_valid_nxt   = out_valid_r && !out_tready;
    out_status_nxt  = out_status_r;
    out_index_nxt   = out_index_r;
    out_payload_nxt = out_payload_r;
    t_raddr         = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          qtime_nxt = in_time;
          if (is_append) begin
            // append: report the new index, or flag a full table
            out_valid_nxt   = 1'b1;
            out_payload_nxt = '0;
            if (full) begin
              out_status_nxt = ntcl_pkg::ST_FULL;
              out_index_nxt  = '0;
            end else begin
              out_status_nxt = ntcl_pkg::ST_OK;
              out_index_nxt  = count_r[IDX_W-1:0];
              count_nxt      = count_r + ntcl_pkg::COUNT_ONE;
            end
          end else if (count_r == '0) begin
            out_valid_nxt   = 1'b1;
            out_status_nxt  = ntcl_pkg::ST_EMPTY;
            out_index_nxt   = '0;
            out_payload_nxt = '0;
          end else begin
            state_nxt = S_CHK0;
          end
        end
      end

      S_CHK0: begin
        if (qtime_r < t_rdata) begin
          // hold address zero until the result register frees up
          if (out_free) begin
            out_valid_nxt   = 1'b1;
            out_status_nxt  = ntcl_pkg::ST_BELOW;
            out_index_nxt   = '0;
            out_payload_nxt = '0;
            state_nxt       = S_IDLE;
          end
        end else begin
          t_raddr   = last_idx;
          state_nxt = S_CHKL;
        end
      end

      S_CHKL: begin
        t_raddr = last_idx;
        if (qtime_r > t_rdata) begin
          if (out_free) begin
            out_valid_nxt   = 1'b1;
            out_status_nxt  = ntcl_pkg::ST_ABOVE;
            out_index_nxt   = '0;
            out_payload_nxt = '0;
            state_nxt       = S_IDLE;
          end
        end else if (qtime_r == t_rdata) begin
          pick_nxt  = last_idx;
          state_nxt = S_PAYW;
        end else begin
          // scan from the cursor; the cursor itself is the fallback pick
          idx_nxt   = cursor_fix;
          pick_nxt  = cursor_fix;
          t_raddr   = cursor_fix;
          state_nxt = S_SCAN;
        end
      end

      S_SCAN: begin
        if (t_rdata > qtime_r) begin
          if (idx_r == '0) begin
            pick_nxt  = '0;
            state_nxt = S_PAYW;
          end else begin
            dhi_nxt   = t_rdata - qtime_r;
            t_raddr   = idx_r - ntcl_pkg::IDX_ONE;
            state_nxt = S_PREV;
          end
        end else if (idx_r == last_idx) begin
          state_nxt = S_PAYW;
        end else begin
          idx_nxt = idx_r + ntcl_pkg::IDX_ONE;
          t_raddr = idx_r + ntcl_pkg::IDX_ONE;
        end
      end

      S_PREV: begin
        dlo_nxt   = (t_rdata >= qtime_r) ? (t_rdata - qtime_r) : (qtime_r - t_rdata);
        state_nxt = S_CMP;
      end

      S_CMP: begin
        // a tie goes to the later entry
        pick_nxt  = (dlo_r < dhi_r) ? (idx_r - ntcl_pkg::IDX_ONE) : idx_r;
        state_nxt = S_PAYW;
      end

      S_PAYW: begin
        state_nxt = S_PAY;
      end

      S_PAY: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_status_nxt  = ntcl_pkg::ST_OK;
          out_index_nxt   = pick_r;
          out_payload_nxt = p_rdata;
          cursor_nxt      = pick_r;
          state_nxt       = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      cursor_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      cursor_r    <= cursor_nxt;
      out_valid_r <= out_valid_nxt;
    end
    idx_r         <= idx_nxt;
    pick_r        <= pick_nxt;
    qtime_r       <= qtime_nxt;
    dhi_r         <= dhi_nxt;
    dlo_r         <= dlo_nxt;
    out_status_r  <= out_status_nxt;
    out_index_r   <= out_index_nxt;
    out_payload_r <= out_payload_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_payload_r, out_index_r, out_status_r};

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= ntcl_pkg::COUNT_FULL)
    else $error("entry count exceeds table depth");

  a_cursor_in_table: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != '0 |-> {1'b0, cursor_r} < count_r)
    else $error("cursor points past the last entry");

  a_full_append: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && is_append && full |=>
      out_valid_r && out_status_r == ntcl_pkg::ST_FULL && $stable(count_r))
    else $error("append to full table not flagged");

  a_ok_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r == ntcl_pkg::ST_OK |-> {1'b0, out_index_r} < count_r)
    else $error("result index outside the table");

  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r != ntcl_pkg::ST_OK |->
      out_index_r == '0 && out_payload_r == '0)
    else $error("error result carries nonzero index or payload");
`endif

endmodule

`default_nettype wire
